[hdl/multi_width_integer_alu_assert.svh]
// Assertion macros for the ALU RTL file.
`ifndef MULTI_WIDTH_INTEGER_ALU_ASSERT_SVH
`define MULTI_WIDTH_INTEGER_ALU_ASSERT_SVH

// Checked at every rising edge outside reset.
`define MWIA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define MWIA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/mwia_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package mwia_pkg;

  typedef struct packed {
    logic [4:0]  opcode;
    logic [1:0]  width_code;
    logic        is_signed;
    logic [63:0] operand_a;
    logic [63:0] operand_b;
  } op_word_t;

  typedef struct packed {
    logic [63:0] result;
    logic        divide_by_zero;
  } res_word_t;

  localparam logic [4:0] OP_ADD     = 5'd0;
  localparam logic [4:0] OP_SUB     = 5'd1;
  localparam logic [4:0] OP_MUL     = 5'd2;
  localparam logic [4:0] OP_DIV     = 5'd3;
  localparam logic [4:0] OP_MOD     = 5'd4;
  localparam logic [4:0] OP_AND     = 5'd5;
  localparam logic [4:0] OP_OR      = 5'd6;
  localparam logic [4:0] OP_XOR     = 5'd7;
  localparam logic [4:0] OP_SHL     = 5'd8;
  localparam logic [4:0] OP_SHR     = 5'd9;
  localparam logic [4:0] OP_EQ      = 5'd10;
  localparam logic [4:0] OP_NE      = 5'd11;
  localparam logic [4:0] OP_LT      = 5'd12;
  localparam logic [4:0] OP_LE      = 5'd13;
  localparam logic [4:0] OP_GT      = 5'd14;
  localparam logic [4:0] OP_GE      = 5'd15;
  localparam logic [4:0] OP_CMP3    = 5'd16;
  localparam logic [4:0] OP_INC     = 5'd17;
  localparam logic [4:0] OP_DEC     = 5'd18;
  localparam logic [4:0] OP_NEG     = 5'd19;
  localparam logic [4:0] OP_INVERT  = 5'd20;
  localparam logic [4:0] OP_NONZERO = 5'd21;
  localparam logic [4:0] OP_ZERO    = 5'd22;
  localparam logic [4:0] OP_SEXT    = 5'd23;

  localparam logic [1:0] WIDTH_8  = 2'd0;
  localparam logic [1:0] WIDTH_16 = 2'd1;
  localparam logic [1:0] WIDTH_32 = 2'd2;
  localparam logic [1:0] WIDTH_64 = 2'd3;

endpackage

`default_nettype wire

[hdl/multi_width_integer_alu.sv]
// Integer ALU for constant folding, one operation per word.
// The op channel (op_valid, op_stall, op_word) carries an opcode, a width code,
// a signedness flag and two 64-bit operands. The res channel (res_valid,
// res_stall, res_word) returns the result, zero-extended from the operand width
// (sign-extended for OP_SEXT), and a divide-by-zero flag. Every op word yields
// exactly one res word, in order. The pipeline is DATA_WIDTH + 3 stages deep:
// an operand decode stage, an evaluate stage with the partial products of the
// multiplier, one stage per quotient bit of the restoring divider, and the
// output register. One word is taken every cycle while op_stall is low.
// Widths above DATA_WIDTH are treated as DATA_WIDTH bits.
// A stall on the res channel holds the output register; stages behind it keep
// filling empty slots, so op_stall rises only once the pipeline is full.
// Reset empties all stages; res_valid is low in the cycle after reset.
`timescale 1ns / 1ps
`default_nettype none

`include "multi_width_integer_alu_assert.svh"

module multi_width_integer_alu
  import mwia_pkg::*;
#(
  parameter int DATA_WIDTH = 64
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      op_valid,
  output logic           op_stall,
  input  wire op_word_t  op_word,
  output logic           res_valid,
  input  wire logic      res_stall,
  output res_word_t      res_word
);

  localparam int DW = DATA_WIDTH;
  localparam int H  = DW / 2;
  localparam int HI = DW - H;
  localparam int SW = $clog2(DW);

  typedef struct packed {
    logic [4:0]    op;
    logic          sg;
    logic [6:0]    wb;
    logic [DW-1:0] mask;
    logic [DW-1:0] a;
    logic [DW-1:0] b;
    logic [DW-1:0] sa;
    logic [DW-1:0] sb;
  } dec_t;

  typedef struct packed {
    logic [4:0]    op;
    logic [DW-1:0] mask;
    logic          neg_q;
    logic          neg_r;
    logic          dz;
    logic [DW-1:0] ma;
    logic [DW-1:0] mb;
    logic [DW-1:0] res;
    logic [DW-1:0] ll;
    logic [HI-1:0] lh;
    logic [HI-1:0] hl;
  } eval_t;

  typedef struct packed {
    logic [4:0]    op;
    logic [DW-1:0] mask;
    logic          neg_q;
    logic          neg_r;
    logic          dz;
    logic [DW-1:0] rem;
    logic [DW-1:0] quo;
    logic [DW-1:0] dvs;
    logic [DW-1:0] res;
  } div_t;

  function automatic div_t div_step(div_t s);
    div_t          n;
    logic [DW:0]   r2;
    logic          qb;
    n  = s;
    r2 = {s.rem, s.quo[DW-1]};
    qb = (r2 >= {1'b0, s.dvs});
    if (qb) begin
      r2 = r2 - {1'b0, s.dvs};
    end
    n.rem = r2[DW-1:0];
    n.quo = {s.quo[DW-2:0], qb};
    return n;
  endfunction

  logic          dec_valid;
  dec_t          dec;
  dec_t          dec_next;
  logic          eval_valid;
  eval_t         eval;
  eval_t         eval_next;
  logic [DW-1:0] div_valid;
  div_t          div_first;
  div_t          div_st [DW];
  div_t          div_in [DW];
  logic          out_valid;
  res_word_t     out_word;
  res_word_t     out_next;

  logic          dec_en;
  logic          eval_en;
  logic [DW-1:0] div_en;
  logic          out_en;

  assign out_en  = !out_valid || !res_stall;
  assign div_en[DW-1] = !div_valid[DW-1] || out_en;
  for (genvar k = 0; k < DW - 1; k++) begin : g_en
    assign div_en[k] = !div_valid[k] || div_en[k+1];
  end
  assign eval_en  = !eval_valid || div_en[0];
  assign dec_en   = !dec_valid || eval_en;
  assign op_stall = !dec_en;

  always_comb begin
    logic [DW-1:0] a_in;
    logic [DW-1:0] b_in;
    logic          sgn_a;
    logic          sgn_b;
    dec_next      = '0;
    dec_next.op   = op_word.opcode;
    dec_next.sg   = op_word.is_signed;
    case (op_word.width_code)
      WIDTH_8:  dec_next.wb = 7'd8;
      WIDTH_16: dec_next.wb = 7'd16;
      WIDTH_32: dec_next.wb = 7'd32;
      default:  dec_next.wb = 7'd64;
    endcase
    if (dec_next.wb > 7'(DW)) begin
      dec_next.wb = 7'(DW);
    end
    for (int i = 0; i < DW; i++) begin
      dec_next.mask[i] = (7'(i) < dec_next.wb);
    end
    a_in = op_word.operand_a[DW-1:0] & dec_next.mask;
    b_in = op_word.operand_b[DW-1:0] & dec_next.mask;
    case (op_word.width_code)
      WIDTH_8: begin
        sgn_a = a_in[7];
        sgn_b = b_in[7];
      end
      WIDTH_16: begin
        sgn_a = a_in[15];
        sgn_b = b_in[15];
      end
      WIDTH_32: begin
        sgn_a = a_in[31];
        sgn_b = b_in[31];
      end
      default: begin
        sgn_a = a_in[DW-1];
        sgn_b = b_in[DW-1];
      end
    endcase
    dec_next.a  = a_in;
    dec_next.b  = b_in;
    dec_next.sa = a_in | (sgn_a ? ~dec_next.mask : '0);
    dec_next.sb = b_in | (sgn_b ? ~dec_next.mask : '0);
  end

  always_comb begin
    logic          lt;
    logic          gt;
    logic          big;
    logic [SW-1:0] amt;
    logic          na;
    logic          nb;
    logic [2*H-1:0] llp;
    lt  = dec.sg ? ($signed(dec.sa) < $signed(dec.sb)) : (dec.a < dec.b);
    gt  = dec.sg ? ($signed(dec.sb) < $signed(dec.sa)) : (dec.b < dec.a);
    big = (dec.b >= DW'(dec.wb));
    amt = dec.b[SW-1:0];
    na  = dec.sg && dec.sa[DW-1];
    nb  = dec.sg && dec.sb[DW-1];
    llp = dec.a[H-1:0] * dec.b[H-1:0];
    eval_next       = '0;
    eval_next.op    = dec.op;
    eval_next.mask  = dec.mask;
    eval_next.neg_q = na ^ nb;
    eval_next.neg_r = na;
    eval_next.dz    = (dec.b == '0) && ((dec.op == OP_DIV) || (dec.op == OP_MOD));
    eval_next.ma    = na ? (DW'(0) - dec.sa) : dec.a;
    eval_next.mb    = nb ? (DW'(0) - dec.sb) : dec.b;
    eval_next.ll    = DW'(llp);
    eval_next.lh    = HI'(dec.a[H-1:0] * dec.b[DW-1:H]);
    eval_next.hl    = HI'(dec.a[DW-1:H] * dec.b[H-1:0]);
    case (dec.op)
      OP_ADD:     eval_next.res = dec.a + dec.b;
      OP_SUB:     eval_next.res = dec.a - dec.b;
      OP_AND:     eval_next.res = dec.a & dec.b;
      OP_OR:      eval_next.res = dec.a | dec.b;
      OP_XOR:     eval_next.res = dec.a ^ dec.b;
      OP_SHL:     eval_next.res = big ? '0 : (dec.a << amt);
      OP_SHR: begin
        if (big) begin
          eval_next.res = '0;
        end else if (dec.sg) begin
          eval_next.res = DW'($signed(dec.sa) >>> amt);
        end else begin
          eval_next.res = dec.a >> amt;
        end
      end
      OP_EQ:      eval_next.res = DW'(dec.a == dec.b);
      OP_NE:      eval_next.res = DW'(dec.a != dec.b);
      OP_LT:      eval_next.res = DW'(lt);
      OP_LE:      eval_next.res = DW'(!gt);
      OP_GT:      eval_next.res = DW'(gt);
      OP_GE:      eval_next.res = DW'(!lt);
      OP_CMP3:    eval_next.res = lt ? '1 : DW'(gt);
      OP_INC:     eval_next.res = dec.a + DW'(1);
      OP_DEC:     eval_next.res = dec.a - DW'(1);
      OP_NEG:     eval_next.res = DW'(0) - dec.a;
      OP_INVERT:  eval_next.res = ~dec.a;
      OP_NONZERO: eval_next.res = DW'(dec.a != '0);
      OP_ZERO:    eval_next.res = DW'(dec.a == '0);
      OP_SEXT:    eval_next.res = dec.sa;
      default:    eval_next.res = '0;
    endcase
  end

  always_comb begin
    div_first       = '0;
    div_first.op    = eval.op;
    div_first.mask  = eval.mask;
    div_first.neg_q = eval.neg_q;
    div_first.neg_r = eval.neg_r;
    div_first.dz    = eval.dz;
    div_first.rem   = '0;
    div_first.quo   = eval.ma;
    div_first.dvs   = eval.mb;
    div_first.res   = (eval.op == OP_MUL) ?
                      (eval.ll + {eval.lh + eval.hl, {H{1'b0}}}) : eval.res;
  end

  assign div_in[0] = div_step(div_first);

  for (genvar k = 1; k < DW; k++) begin : g_div
    assign div_in[k] = div_step(div_st[k-1]);
  end

  always_comb begin
    div_t          l;
    logic [DW-1:0] r;
    l = div_st[DW-1];
    case (l.op)
      OP_DIV:  r = l.neg_q ? (DW'(0) - l.quo) : l.quo;
      OP_MOD:  r = l.neg_r ? (DW'(0) - l.rem) : l.rem;
      default: r = l.res;
    endcase
    if (l.dz) begin
      r = '0;
    end
    if (l.op != OP_SEXT) begin
      r = r & l.mask;
    end
    out_next.result         = 64'(r);
    out_next.divide_by_zero = l.dz;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dec_valid  <= 1'b0;
      eval_valid <= 1'b0;
      div_valid  <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (dec_en) begin
        dec_valid <= op_valid;
      end
      if (eval_en) begin
        eval_valid <= dec_valid;
      end
      if (div_en[0]) begin
        div_valid[0] <= eval_valid;
      end
      for (int k = 1; k < DW; k++) begin
        if (div_en[k]) begin
          div_valid[k] <= div_valid[k-1];
        end
      end
      if (out_en) begin
        out_valid <= div_valid[DW-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dec_en) begin
      dec <= dec_next;
    end
    if (eval_en) begin
      eval <= eval_next;
    end
    for (int k = 0; k < DW; k++) begin
      if (div_en[k]) begin
        div_st[k] <= div_in[k];
      end
    end
    if (out_en) begin
      out_word <= out_next;
    end
  end

  assign res_valid = out_valid;
  assign res_word  = out_word;

  `MWIA_ASSERT(a_dz_zero, res_valid && res_word.divide_by_zero |-> res_word.result == '0, "divide by zero word carries a nonzero result")
  `MWIA_ASSERT(a_dz_op, eval_valid && eval.dz |-> (eval.op == OP_DIV) || (eval.op == OP_MOD), "zero divisor flag on an operation that does not divide")
  `MWIA_ASSERT_ALWAYS(a_stall_full, op_stall |-> dec_valid, "input stalled while the decode stage is empty")
  `MWIA_ASSERT_ALWAYS(a_reset_empty, rst |=> !res_valid, "result valid right after reset")

endmodule

`default_nettype wire
